// ----- hw/rtl/svt_pkg.sv -----
// Shared widths, operation and status codes for the snapshot version tracker.
package svt_pkg;

	// Table geometry
	localparam int MAX_SNAPSHOTS = 64;
	localparam int ADDR_W        = $clog2(MAX_SNAPSHOTS);
	localparam int CNT_W         = $clog2(MAX_SNAPSHOTS + 1);

	// Field widths
	localparam int VER_W  = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int LIVE_W = 7;

	typedef logic [VER_W-1:0]  ver_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam ver_t VERSION_RESET = ver_t'(1);
	localparam ver_t VERSION_MAX   = '1;

	// Operation codes
	localparam op_t OP_TAKE    = 2'd0;
	localparam op_t OP_BUMP    = 2'd1;
	localparam op_t OP_RELEASE = 2'd2;

	// Status codes
	localparam stat_t ST_OK        = 2'd0;
	localparam stat_t ST_FULL      = 2'd1;
	localparam stat_t ST_NOT_FOUND = 2'd2;
	localparam stat_t ST_SATURATED = 2'd3;

endpackage

// ----- hw/rtl/svt_req_if.sv -----
// Request channel: one operation per beat.
interface svt_req_if;
	logic          valid;
	logic          ready;
	svt_pkg::op_t  op;
	svt_pkg::ver_t release_version;

	modport source (output valid, output op, output release_version, input ready);
	modport sink   (input valid, input op, input release_version, output ready);
endinterface

// ----- hw/rtl/svt_rsp_if.sv -----
// Response channel: one result per beat.
interface svt_rsp_if;
	logic                          valid;
	logic                          ready;
	svt_pkg::ver_t                 result_version;
	svt_pkg::stat_t                status;
	logic [svt_pkg::LIVE_W-1:0]    live_snapshots;
	svt_pkg::ver_t                 current_version;
	svt_pkg::ver_t                 oldest_snapshot;
	svt_pkg::ver_t                 gc_backlog;

	modport source (output valid, output result_version, output status,
		output live_snapshots, output current_version, output oldest_snapshot,
		output gc_backlog, input ready);
	modport sink   (input valid, input result_version, input status,
		input live_snapshots, input current_version, input oldest_snapshot,
		input gc_backlog, output ready);
endinterface

// ----- hw/rtl/snapshot_version_tracker_unit.sv -----
// Snapshot version tracker: version counter and table of live snapshots.
//
// Channels: req carries one operation per beat (take snapshot, bump version,
// release snapshot); rsp returns exactly one result beat per request with the
// result version, status, live count, current version, oldest live snapshot
// and garbage backlog.
// Steps: take, bump, the unused op code and a release of zero go from accept
// straight to the done step, which loads the rsp register. A release of a
// nonzero version scans the snapshot RAM one entry per cycle, then, when an
// entry is removed, reads the last entry and writes it into the freed slot
// before the done step. The snapshot RAM has a single read port, so the scan
// reads the live entries one by one, up to all 64 of a full table.
// One request is in work at a time; req.ready is high while the sequencer is
// idle, including while a finished result still waits in the rsp register.
// If the receiver stalls rsp, a finished request waits in its last step until
// the response register frees, and the block takes no further request.
// Reset: version counter 1, no live snapshots, rsp empty. The RAM needs no
// clearing; only entries below the live count are ever read.
module snapshot_version_tracker_unit (
	input logic     clk,
	input logic     arst_n,
	svt_req_if.sink req,
	svt_rsp_if.source rsp
);

	// Sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_MOVE_RD = 3'd2;
	localparam logic [2:0] S_MOVE_WR = 3'd3;
	localparam logic [2:0] S_DONE    = 3'd4;

	logic [2:0]          state_q;
	svt_pkg::ver_t       ver_q;
	svt_pkg::cnt_t       live_q;
	svt_pkg::ver_t       min_q;
	svt_pkg::cnt_t       rd_cnt_q;
	logic                rd_pend_s1;
	svt_pkg::addr_t      rd_idx_s1;
	logic                found_q;
	svt_pkg::addr_t      hit_idx_q;
	svt_pkg::ver_t       rel_q;
	svt_pkg::ver_t       res_q;
	svt_pkg::stat_t      stat_q;

	logic                out_valid_q;
	svt_pkg::ver_t       out_res_q;
	svt_pkg::stat_t      out_stat_q;
	logic [svt_pkg::LIVE_W-1:0] out_live_q;
	svt_pkg::ver_t       out_ver_q;
	svt_pkg::ver_t       out_old_q;
	svt_pkg::ver_t       out_gc_q;

	logic                accept;
	logic                has_room;
	logic                scan_issue;
	logic                scan_end;
	logic                out_free;

	logic                ram_wr_en;
	svt_pkg::addr_t      ram_wr_addr;
	svt_pkg::ver_t       ram_wr_data;
	logic                ram_rd_en;
	svt_pkg::addr_t      ram_rd_addr;
	svt_pkg::ver_t       ram_rd_data;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign has_room   = (live_q < svt_pkg::cnt_t'(svt_pkg::MAX_SNAPSHOTS));
	assign scan_issue = (state_q == S_SCAN) && (rd_cnt_q < live_q);
	assign scan_end   = (state_q == S_SCAN) && (rd_cnt_q == live_q) && !rd_pend_s1;
	assign out_free   = !out_valid_q || rsp.ready;

	// Steer the RAM ports: take appends, move fills the freed slot
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = hit_idx_q;
		ram_wr_data = ram_rd_data;
		if (accept && (req.op == svt_pkg::OP_TAKE) && has_room) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = live_q[svt_pkg::ADDR_W-1:0];
			ram_wr_data = ver_q;
		end else if (state_q == S_MOVE_WR) begin
			ram_wr_en = 1'b1;
		end
		ram_rd_en   = scan_issue || (state_q == S_MOVE_RD);
		ram_rd_addr = (state_q == S_MOVE_RD) ? live_q[svt_pkg::ADDR_W-1:0]
			: rd_cnt_q[svt_pkg::ADDR_W-1:0];
	end

	svt_ram #(
		.WIDTH(svt_pkg::VER_W),
		.DEPTH(svt_pkg::MAX_SNAPSHOTS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ver_q      <= svt_pkg::VERSION_RESET;
			live_q     <= '0;
			rd_cnt_q   <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rel_q <= req.release_version;
						unique case (req.op)
							svt_pkg::OP_TAKE: begin
								state_q <= S_DONE;
								if (has_room) begin
									live_q <= live_q + svt_pkg::cnt_t'(1);
									res_q  <= ver_q;
									stat_q <= svt_pkg::ST_OK;
									// newest version never lowers the minimum
									if (live_q == '0) begin
										min_q <= ver_q;
									end
								end else begin
									res_q  <= '0;
									stat_q <= svt_pkg::ST_FULL;
								end
							end
							svt_pkg::OP_BUMP: begin
								state_q <= S_DONE;
								if (ver_q == svt_pkg::VERSION_MAX) begin
									stat_q <= svt_pkg::ST_SATURATED;
									res_q  <= ver_q;
								end else begin
									stat_q <= svt_pkg::ST_OK;
									ver_q  <= ver_q + svt_pkg::ver_t'(1);
									res_q  <= ver_q + svt_pkg::ver_t'(1);
								end
							end
							svt_pkg::OP_RELEASE: begin
								res_q <= '0;
								if (req.release_version == '0) begin
									stat_q  <= svt_pkg::ST_NOT_FOUND;
									state_q <= S_DONE;
								end else begin
									stat_q     <= svt_pkg::ST_OK;
									rd_cnt_q   <= '0;
									rd_pend_s1 <= 1'b0;
									found_q    <= 1'b0;
									min_q      <= '1;
									state_q    <= S_SCAN;
								end
							end
							default: begin
								res_q   <= '0;
								stat_q  <= svt_pkg::ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// issue one read per cycle
					rd_pend_s1 <= scan_issue;
					if (scan_issue) begin
						rd_idx_s1 <= rd_cnt_q[svt_pkg::ADDR_W-1:0];
						rd_cnt_q  <= rd_cnt_q + svt_pkg::cnt_t'(1);
					end
					// match the first hit, fold the rest into the minimum
					if (rd_pend_s1) begin
						if (!found_q && (ram_rd_data == rel_q)) begin
							found_q   <= 1'b1;
							hit_idx_q <= rd_idx_s1;
						end else if (ram_rd_data < min_q) begin
							min_q <= ram_rd_data;
						end
					end
					if (scan_end) begin
						if (found_q) begin
							live_q  <= live_q - svt_pkg::cnt_t'(1);
							state_q <= S_MOVE_RD;
						end else begin
							stat_q  <= svt_pkg::ST_NOT_FOUND;
							state_q <= S_DONE;
						end
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response register: load on finish, drop on accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
			out_live_q <= svt_pkg::LIVE_W'(live_q);
			out_ver_q  <= ver_q;
			if (live_q != '0) begin
				out_old_q <= min_q;
				out_gc_q  <= ver_q - min_q;
			end else begin
				out_old_q <= ver_q;
				out_gc_q  <= '0;
			end
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.result_version  = out_res_q;
	assign rsp.status          = out_stat_q;
	assign rsp.live_snapshots  = out_live_q;
	assign rsp.current_version = out_ver_q;
	assign rsp.oldest_snapshot = out_old_q;
	assign rsp.gc_backlog      = out_gc_q;

endmodule

// ----- hw/rtl/svt_ram.sv -----
// Generic simple dual-port RAM with registered read.
module svt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/svt_checker.sv -----
// Port-level assertions for the snapshot version tracker, bound to the top level.
module svt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input svt_pkg::ver_t              rsp_result_version,
	input svt_pkg::stat_t             rsp_status,
	input logic [svt_pkg::LIVE_W-1:0] rsp_live_snapshots,
	input svt_pkg::ver_t              rsp_current_version,
	input svt_pkg::ver_t              rsp_oldest_snapshot,
	input svt_pkg::ver_t              rsp_gc_backlog
);

	// Hold a stalled beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_version)
			&& $stable(rsp_current_version))
		else $error("rsp beat changed while stalled");

	// Backlog is current minus oldest, zero with no live snapshots
	a_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_live_snapshots == '0) ? (rsp_gc_backlog == '0
			&& rsp_oldest_snapshot == rsp_current_version)
			: (rsp_gc_backlog == rsp_current_version - rsp_oldest_snapshot)))
		else $error("gc backlog inconsistent with oldest and current version");

	// Full table gives no version and a full count
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == svt_pkg::ST_FULL) |-> (rsp_result_version == '0)
			&& (rsp_live_snapshots == svt_pkg::LIVE_W'(svt_pkg::MAX_SNAPSHOTS)))
		else $error("table full reported with a version or a short count");

	// Saturation only at the top of the version range
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == svt_pkg::ST_SATURATED)
			|-> (rsp_current_version == svt_pkg::VERSION_MAX)
			&& (rsp_result_version == svt_pkg::VERSION_MAX))
		else $error("saturation reported below the maximum version");

	// Oldest snapshot never lies above the current version
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_oldest_snapshot <= rsp_current_version)
			&& (rsp_current_version != '0))
		else $error("oldest snapshot above current version");

endmodule

bind snapshot_version_tracker_unit svt_checker u_svt_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_result_version  (rsp.result_version),
	.rsp_status          (rsp.status),
	.rsp_live_snapshots  (rsp.live_snapshots),
	.rsp_current_version (rsp.current_version),
	.rsp_oldest_snapshot (rsp.oldest_snapshot),
	.rsp_gc_backlog      (rsp.gc_backlog)
);

// ----- tb/tb_snapshot_version_tracker_unit.sv -----
// Self-checking testbench for the snapshot version tracker: directed table, then random bursts.
`timescale 1ns / 1ps

module tb_snapshot_version_tracker_unit;
	import svt_pkg::*;

	localparam int unsigned N_RANDOM   = 830;
	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned LONG_HOLD  = 300;
	localparam op_t         OP_UNUSED  = 2'd3;

	typedef struct packed {
		ver_t              result_version;
		stat_t             status;
		logic [LIVE_W-1:0] live_snapshots;
		ver_t              current_version;
		ver_t              oldest_snapshot;
		ver_t              gc_backlog;
	} tracker_rsp_t;

	typedef struct {
		op_t          op;
		ver_t         rel;
		bit           known;
		tracker_rsp_t want;
	} stim_row_t;

	typedef enum {M_FILL, M_DRAIN, M_MIXED} burst_mode_t;

	logic clk;
	logic arst_n;

	svt_req_if req_ch();
	svt_rsp_if rsp_ch();

	snapshot_version_tracker_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the tracker state
	ver_t        snap_tbl [MAX_SNAPSHOTS];
	int unsigned live_cnt = 0;
	ver_t        ver_now  = VERSION_RESET;

	tracker_rsp_t pending_rsp [$];
	stim_row_t    stim_tbl [$];
	int unsigned  req_taken = 0;
	int unsigned  rsp_seen  = 0;
	int unsigned  err_cnt   = 0;
	int unsigned  idle_cycles = 0;

	// Clock and reset
	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Apply one operation to the shadow state and return its result beat
	function automatic tracker_rsp_t track_op(op_t op, ver_t rel);
		tracker_rsp_t r;
		int unsigned  k;
		bit           hit;
		ver_t         low;
		r        = '0;
		r.status = ST_OK;
		hit      = 1'b0;
		case (op)
			OP_TAKE: begin
				if (live_cnt >= MAX_SNAPSHOTS) begin
					r.status = ST_FULL;
				end else begin
					snap_tbl[live_cnt] = ver_now;
					live_cnt++;
					r.result_version = ver_now;
				end
			end
			OP_BUMP: begin
				if (ver_now == VERSION_MAX)
					r.status = ST_SATURATED;
				else
					ver_now++;
				r.result_version = ver_now;
			end
			OP_RELEASE: begin
				r.status = ST_NOT_FOUND;
				// remove one match; the last entry fills the hole
				if (rel != '0) begin
					for (k = 0; k < live_cnt && !hit; k++) begin
						if (snap_tbl[k] == rel) begin
							hit = 1'b1;
							live_cnt--;
							snap_tbl[k] = snap_tbl[live_cnt];
							r.status = ST_OK;
						end
					end
				end
			end
			default: ;
		endcase
		low = ver_now;
		for (k = 0; k < live_cnt; k++)
			if (k == 0 || snap_tbl[k] < low)
				low = snap_tbl[k];
		r.live_snapshots  = LIVE_W'(live_cnt);
		r.current_version = ver_now;
		r.oldest_snapshot = low;
		r.gc_backlog      = (live_cnt > 0) ? ver_now - low : '0;
		return r;
	endfunction

	function automatic tracker_rsp_t mk_rsp(ver_t res, stat_t st, int unsigned live, ver_t cur,
			ver_t old, ver_t bl);
		tracker_rsp_t r;
		r.result_version  = res;
		r.status          = st;
		r.live_snapshots  = LIVE_W'(live);
		r.current_version = cur;
		r.oldest_snapshot = old;
		r.gc_backlog      = bl;
		return r;
	endfunction

	task automatic add_row(op_t op, ver_t rel, bit known, tracker_rsp_t want);
		stim_row_t row;
		row.op    = op;
		row.rel   = rel;
		row.known = known;
		row.want  = want;
		stim_tbl.push_back(row);
	endtask

	// Idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Versions that are almost surely not live
	function automatic ver_t absent_version();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return VERSION_MAX;
			2: return $urandom();
			3: return ver_now + ver_t'($urandom_range(1, 5));
			default: return ver_t'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic ver_t live_version();
		if (live_cnt == 0)
			return absent_version();
		return snap_tbl[$urandom_range(0, live_cnt - 1)];
	endfunction

	task automatic next_random(input burst_mode_t mode, output op_t op, output ver_t rel);
		int unsigned r;
		r   = $urandom_range(0, 99);
		rel = $urandom();
		case (mode)
			M_FILL: begin
				if (r < 80) begin
					op = OP_TAKE;
				end else if (r < 95) begin
					op = OP_BUMP;
				end else begin
					op  = OP_RELEASE;
					rel = live_version();
				end
			end
			M_DRAIN: begin
				if (r < 80) begin
					op  = OP_RELEASE;
					rel = live_version();
				end else if (r < 90) begin
					op  = OP_RELEASE;
					rel = absent_version();
				end else begin
					op = OP_BUMP;
				end
			end
			default: begin
				if (r < 30) begin
					op = OP_TAKE;
				end else if (r < 55) begin
					op = OP_BUMP;
				end else if (r < 92) begin
					op  = OP_RELEASE;
					rel = ($urandom_range(0, 1) == 0) ? live_version() : absent_version();
				end else begin
					op = OP_UNUSED;
				end
			end
		endcase
	endtask

	// Offer one beat, hold it until taken, then record the expected result
	task automatic send_item(op_t op, ver_t rel, bit known, tracker_rsp_t want, bit calm);
		tracker_rsp_t predicted;
		int unsigned  gap;
		gap = calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.op              <= op;
		req_ch.release_version <= rel;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = track_op(op, rel);
		pending_rsp.push_back(known ? want : predicted);
		req_taken++;
	endtask

	// Drop valid and hold until every result is back
	task automatic wait_all_done();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Request side
	initial begin
		op_t         op;
		ver_t        rel;
		burst_mode_t mode;
		int unsigned len;
		int unsigned ep;
		int unsigned sent;
		bit          calm;
		bit          paused_once;
		req_ch.valid           = 1'b0;
		req_ch.op              = OP_TAKE;
		req_ch.release_version = '0;
		paused_once            = 1'b0;

		// Directed rows: typed results where obvious, predictor elsewhere
		add_row(OP_UNUSED,  32'h0,        1, mk_rsp(0, ST_OK,        0, 1, 1, 0));
		add_row(OP_RELEASE, 32'h0,        1, mk_rsp(0, ST_NOT_FOUND, 0, 1, 1, 0));
		add_row(OP_RELEASE, 32'hFFFFFFFF, 1, mk_rsp(0, ST_NOT_FOUND, 0, 1, 1, 0));
		add_row(OP_TAKE,    32'hFFFFFFFF, 1, mk_rsp(1, ST_OK,        1, 1, 1, 0));
		add_row(OP_BUMP,    32'h0,        1, mk_rsp(2, ST_OK,        1, 2, 1, 1));
		add_row(OP_TAKE,    32'h0,        1, mk_rsp(2, ST_OK,        2, 2, 1, 1));
		add_row(OP_TAKE,    32'h5555AAAA, 1, mk_rsp(2, ST_OK,        3, 2, 1, 1));
		add_row(OP_RELEASE, 32'h2,        1, mk_rsp(0, ST_OK,        2, 2, 1, 1));
		add_row(OP_RELEASE, 32'h1,        1, mk_rsp(0, ST_OK,        1, 2, 2, 0));
		add_row(OP_RELEASE, 32'h1,        1, mk_rsp(0, ST_NOT_FOUND, 1, 2, 2, 0));
		add_row(OP_BUMP,    32'hAAAA5555, 1, mk_rsp(3, ST_OK,        1, 3, 2, 1));
		add_row(OP_RELEASE, 32'h2,        1, mk_rsp(0, ST_OK,        0, 3, 3, 0));
		add_row(OP_UNUSED,  32'hFFFFFFFF, 1, mk_rsp(0, ST_OK,        0, 3, 3, 0));
		add_row(OP_TAKE,    32'h0,        0, '0);
		add_row(OP_BUMP,    32'h0,        0, '0);
		add_row(OP_TAKE,    32'h0,        0, '0);
		add_row(OP_RELEASE, 32'h80000000, 0, '0);
		add_row(OP_BUMP,    32'h7FFFFFFF, 0, '0);
		add_row(OP_RELEASE, 32'h4,        0, '0);
		add_row(OP_RELEASE, 32'h3,        0, '0);
		add_row(OP_UNUSED,  32'h7FFFFFFF, 0, '0);

		@(posedge arst_n);
		foreach (stim_tbl[i])
			send_item(stim_tbl[i].op, stim_tbl[i].rel, stim_tbl[i].known, stim_tbl[i].want, 1'b0);
		wait_all_done();

		// Random bursts: fill the table, drain it, mix
		sent = 0;
		ep   = 0;
		while (sent < N_RANDOM) begin
			if (ep == 0) begin
				mode = M_FILL;
				len  = 80;
			end else if (ep == 1) begin
				mode = M_DRAIN;
				len  = 80;
			end else begin
				mode = burst_mode_t'($urandom_range(0, 2));
				len  = $urandom_range(10, 70);
			end
			if (len > N_RANDOM - sent)
				len = N_RANDOM - sent;
			calm = ($urandom_range(0, 3) == 0);
			if ((!paused_once && sent >= N_RANDOM / 2) || $urandom_range(0, 9) == 0) begin
				wait_all_done();
				paused_once = 1'b1;
			end
			repeat (len) begin
				next_random(mode, op, rel);
				send_item(op, rel, 1'b0, '0, calm);
				sent++;
			end
			ep++;
		end

		wait_all_done();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Response side: random stalls, calm stretches, one long hold-off
	initial begin
		int unsigned stall_left;
		int unsigned calm_left;
		bit          held_long;
		rsp_ch.ready = 1'b0;
		stall_left   = 0;
		calm_left    = 0;
		held_long    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!held_long && req_taken >= stim_tbl.size() + 150) begin
					stall_left = LONG_HOLD;
					held_long  = 1'b1;
				end else if (calm_left > 0) begin
					calm_left--;
				end else if ($urandom_range(0, 59) == 0) begin
					calm_left = $urandom_range(30, 120);
				end else begin
					stall_left = pick_gap();
				end
			end
		end
	end

	task automatic check_field(string fname, logic [VER_W-1:0] want, logic [VER_W-1:0] got);
		if (got !== want) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("beat %0d %s: expected %h, got %h", rsp_seen, fname, want, got);
		end
	endtask

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		tracker_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("beat %0d: result with no request outstanding", rsp_seen);
			end else begin
				want = pending_rsp.pop_front();
				check_field("result_version", want.result_version, rsp_ch.result_version);
				check_field("status", VER_W'(want.status), VER_W'(rsp_ch.status));
				check_field("live_snapshots", VER_W'(want.live_snapshots),
					VER_W'(rsp_ch.live_snapshots));
				check_field("current_version", want.current_version, rsp_ch.current_version);
				check_field("oldest_snapshot", want.oldest_snapshot, rsp_ch.oldest_snapshot);
				check_field("gc_backlog", want.gc_backlog, rsp_ch.gc_backlog);
			end
			rsp_seen++;
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
